[hw/rtl/bsc_pkg.sv]
// Shared types, constants and helpers for the barometric sensor compensation block.
`default_nettype none
package bsc_pkg;

  // Register indexes of the configuration port
  localparam logic [1:0] RegTemp   = 2'd0;
  localparam logic [1:0] RegPressA = 2'd1;
  localparam logic [1:0] RegPressB = 2'd2;
  localparam logic [1:0] RegPressC = 2'd3;

  localparam int unsigned CfgW = 48;
  localparam int unsigned RawW = 20;

  // Compensation constants
  localparam logic [63:0] TfOffset  = 64'd128000;
  localparam logic [63:0] PBase     = 64'd1048576;
  localparam logic [63:0] PScale    = 64'd3125;
  localparam logic [63:0] TRound    = 64'd128;
  localparam logic [63:0] Var1Bias  = 64'h0000_8000_0000_0000;

  // Division by 25600 = 1024 * 25: drop 10 bits, then multiply by
  // ceil(2^27 / 25) and keep bits from 27 up; exact for any 32-bit numerator
  localparam logic [22:0] HpaRecip  = 23'd5368710;

  typedef struct packed {
    logic [RawW-1:0] raw_t;
    logic [RawW-1:0] raw_p;
  } item_t;

  // Calibration words, widened to 64 bits (T1 and P1 zero-extended)
  typedef struct packed {
    logic [63:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } coef_t;

  // Control and status between the queue and the front and back
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } q_ctl_t;

  function automatic logic [63:0] sx16(input logic [15:0] w);
    return {{48{w[15]}}, w};
  endfunction

  function automatic logic [63:0] zx16(input logic [15:0] w);
    return {48'd0, w};
  endfunction

endpackage
`default_nettype wire

[hw/rtl/bsc_queue.sv]
// Two-entry queue between the front and the back.
`default_nettype none
module bsc_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire bsc_pkg::item_t  item_i,
  input  wire logic            pop_i,
  output bsc_pkg::item_t       item_o,
  output logic                 full_o,
  output logic                 empty_o
);

  bsc_pkg::item_t mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign item_o  = mem_q[rd_q];

  // pointer and count update
  always_comb begin
    wr_d  = wr_q ^ push_i;
    rd_d  = rd_q ^ pop_i;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/bsc_front.sv]
// Front: configuration registers, coefficient unpacking and input acceptance.
`default_nettype none
module bsc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [bsc_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [bsc_pkg::RawW-1:0]    raw_temperature_i,
  input  wire logic [bsc_pkg::RawW-1:0]    raw_pressure_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output bsc_pkg::item_t                   q_item_o,
  output bsc_pkg::coef_t                   coef_o
);

  logic [bsc_pkg::CfgW-1:0] tc_q, pa_q, pb_q, pc_q;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      pc_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bsc_pkg::RegTemp:   tc_q <= cfg_data_i;
        bsc_pkg::RegPressA: pa_q <= cfg_data_i;
        bsc_pkg::RegPressB: pb_q <= cfg_data_i;
        bsc_pkg::RegPressC: pc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // unpack calibration words
  always_comb begin
    coef_o.t1 = bsc_pkg::zx16(tc_q[15:0]);
    coef_o.t2 = bsc_pkg::sx16(tc_q[31:16]);
    coef_o.t3 = bsc_pkg::sx16(tc_q[47:32]);
    coef_o.p1 = bsc_pkg::zx16(pa_q[15:0]);
    coef_o.p2 = bsc_pkg::sx16(pa_q[31:16]);
    coef_o.p3 = bsc_pkg::sx16(pa_q[47:32]);
    coef_o.p4 = bsc_pkg::sx16(pb_q[15:0]);
    coef_o.p5 = bsc_pkg::sx16(pb_q[31:16]);
    coef_o.p6 = bsc_pkg::sx16(pb_q[47:32]);
    coef_o.p7 = bsc_pkg::sx16(pc_q[15:0]);
    coef_o.p8 = bsc_pkg::sx16(pc_q[31:16]);
    coef_o.p9 = bsc_pkg::sx16(pc_q[47:32]);
  end

  // accept into the queue
  assign in_ready_o     = !q_full_i;
  assign q_push_o       = in_valid_i && !q_full_i;
  assign q_item_o.raw_t = raw_temperature_i;
  assign q_item_o.raw_p = raw_pressure_i;

endmodule
`default_nettype wire

[hw/rtl/bsc_mul.sv]
// 64x64 multiplier, low 64 bits, one 32x32 partial product per cycle.
`default_nettype none
module bsc_mul (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      p_o
);

  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]  ph_q;
  logic        run_q, done_q;
  logic [31:0] ma, mb;
  logic [63:0] prod;

  // partial product select: lo*lo, lo*hi, hi*lo
  always_comb begin
    ma    = (ph_q == 2'd2) ? a_q[63:32] : a_q[31:0];
    mb    = (ph_q == 2'd1) ? b_q[63:32] : b_q[31:0];
    prod  = {32'd0, ma} * {32'd0, mb};
    acc_d = (ph_q == 2'd0) ? prod : acc_q + {prod[31:0], 32'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      ph_q   <= 2'd0;
    end else begin
      done_q <= run_q && (ph_q == 2'd2);
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= 2'd0;
      end else if (run_q) begin
        ph_q <= ph_q + 2'd1;
        if (ph_q == 2'd2) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
    if (run_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule
`default_nettype wire

[hw/rtl/bsc_div.sv]
// Radix-2 restoring divider, signed or unsigned 64/64, one quotient bit per cycle.
`default_nettype none
module bsc_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic        sgn_i,
  input  wire logic [63:0] num_i,
  input  wire logic [63:0] den_i,
  output logic             done_o,
  output logic [63:0]      q_o
);

  logic [63:0] dvd_q, md_q, mn, md;
  logic [64:0] rem_q, rs, rem_d;
  logic [5:0]  cnt_q;
  logic        run_q, done_q, neg_q, nn, nd, ge;

  // operand magnitudes
  always_comb begin
    nn = sgn_i && num_i[63];
    nd = sgn_i && den_i[63];
    mn = nn ? (64'd0 - num_i) : num_i;
    md = nd ? (64'd0 - den_i) : den_i;
  end

  // one quotient bit
  always_comb begin
    rs    = {rem_q[63:0], dvd_q[63]};
    ge    = (rs >= {1'b0, md_q});
    rem_d = ge ? (rs - {1'b0, md_q}) : rs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= run_q && (cnt_q == 6'd0);
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= 6'd63;
      end else if (run_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mn;
      md_q  <= md;
      rem_q <= '0;
      neg_q <= nn ^ nd;
    end else if (run_q) begin
      dvd_q <= {dvd_q[62:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign q_o    = neg_q ? (64'd0 - dvd_q) : dvd_q;

endmodule
`default_nettype wire

[hw/rtl/bsc_back.sv]
// Back: sequencer over the shared multiplier and divider, plus the result register.
`default_nettype none
module bsc_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire bsc_pkg::coef_t            coef_i,
  input  wire logic                      q_empty_i,
  input  wire bsc_pkg::item_t            q_item_i,
  output logic                           q_pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [15:0]             temperature_centi_o,
  output logic [bsc_pkg::RawW-1:0]       pressure_out_o,
  output logic                           pressure_valid_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_A, S_D, S_B, S_XX, S_Y6, S_Y5, S_X3, S_X2, S_X1,
    S_NUM, S_DIV, S_Q1, S_Q2, S_R, S_HPA, S_OUT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic [bsc_pkg::RawW-1:0] at_q, ap_q, hpa_q;
  logic [63:0] a_q, e_q, tf_q, x_q, xx_q, y_q, v_q, xd_q, p_q, qq_q;
  logic        pv_q;

  logic        mul_start, mul_done, div_start, div_done, div_sgn;
  logic [63:0] mul_a, mul_b, m, div_num, div_den, dq;
  logic [63:0] at64, ap64, tf_new, t5;
  logic signed [63:0] ts;
  logic signed [15:0] tc_sat;
  logic [44:0] hpa_prod;
  logic [bsc_pkg::RawW-1:0] hpa_quot;

  assign at64 = {44'd0, at_q};
  assign ap64 = {44'd0, ap_q};

  // operand select for the shared units
  always_comb begin
    mul_a = x_q;
    mul_b = x_q;
    case (state_q)
      S_A:  begin mul_a = (at64 >> 3) - (coef_i.t1 << 1); mul_b = coef_i.t2; end
      S_D:  begin mul_a = (at64 >> 4) - coef_i.t1; mul_b = (at64 >> 4) - coef_i.t1; end
      S_B:  begin mul_a = e_q;  mul_b = coef_i.t3; end
      S_XX: begin mul_a = x_q;  mul_b = x_q; end
      S_Y6: begin mul_a = xx_q; mul_b = coef_i.p6; end
      S_Y5: begin mul_a = x_q;  mul_b = coef_i.p5; end
      S_X3: begin mul_a = xx_q; mul_b = coef_i.p3; end
      S_X2: begin mul_a = x_q;  mul_b = coef_i.p2; end
      S_X1: begin mul_a = v_q + bsc_pkg::Var1Bias; mul_b = coef_i.p1; end
      S_NUM: begin
        mul_a = ((bsc_pkg::PBase - ap64) << 31) - y_q;
        mul_b = bsc_pkg::PScale;
      end
      S_Q1: begin mul_a = coef_i.p9; mul_b = 64'($signed(p_q) >>> 13); end
      S_Q2: begin mul_a = v_q; mul_b = 64'($signed(p_q) >>> 13); end
      S_R:  begin mul_a = coef_i.p8; mul_b = p_q; end
      default: ;
    endcase
    div_sgn  = (state_q == S_DIV);
    div_num  = v_q;
    div_den  = xd_q;
  end

  assign mul_start = !busy_q && (state_q != S_IDLE) && (state_q != S_OUT)
                     && (state_q != S_DIV) && (state_q != S_HPA);
  assign div_start = !busy_q && (state_q == S_DIV);
  assign q_pop_o   = (state_q == S_IDLE) && !q_empty_i;

  // low 32 bits of the Q24.8 pressure over 25600, by reciprocal
  assign hpa_prod = {23'd0, v_q[31:10]} * {22'd0, bsc_pkg::HpaRecip};
  assign hpa_quot = {2'd0, hpa_prod[44:27]};

  bsc_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (m)
  );

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sgn_i   (div_sgn),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .q_o     (dq)
  );

  // temperature in 0.01 degC, saturated
  always_comb begin
    tf_new = a_q + 64'($signed(m) >>> 14);
    t5     = (tf_q << 2) + tf_q + bsc_pkg::TRound;
    ts     = $signed(t5) >>> 8;
    if (ts > 64'sd32767) begin
      tc_sat = 16'sh7fff;
    end else if (ts < -64'sd32768) begin
      tc_sat = -16'sh8000;
    end else begin
      tc_sat = ts[15:0];
    end
  end

  // sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      busy_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i && (state_q != S_OUT)) begin
        out_valid_o <= 1'b0;
      end
      if (mul_start || div_start) begin
        busy_q <= 1'b1;
      end
      if (mul_done || div_done) begin
        busy_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: if (!q_empty_i) state_q <= S_A;
        S_A:    if (mul_done) state_q <= S_D;
        S_D:    if (mul_done) state_q <= S_B;
        S_B:    if (mul_done) state_q <= S_XX;
        S_XX:   if (mul_done) state_q <= S_Y6;
        S_Y6:   if (mul_done) state_q <= S_Y5;
        S_Y5:   if (mul_done) state_q <= S_X3;
        S_X3:   if (mul_done) state_q <= S_X2;
        S_X2:   if (mul_done) state_q <= S_X1;
        S_X1: begin
          if (mul_done) begin
            state_q <= (64'($signed(m) >>> 33) == 64'd0) ? S_OUT : S_NUM;
          end
        end
        S_NUM:  if (mul_done) state_q <= S_DIV;
        S_DIV:  if (div_done) state_q <= S_Q1;
        S_Q1:   if (mul_done) state_q <= S_Q2;
        S_Q2:   if (mul_done) state_q <= S_R;
        S_R:    if (mul_done) state_q <= S_HPA;
        S_HPA:  state_q <= S_OUT;
        S_OUT: begin
          if (!out_valid_o || out_ready_i) begin
            out_valid_o <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        at_q <= q_item_i.raw_t;
        ap_q <= q_item_i.raw_p;
      end
      S_A: if (mul_done) a_q <= 64'($signed(m) >>> 11);
      S_D: if (mul_done) e_q <= 64'($signed(m) >>> 12);
      S_B: begin
        if (mul_done) begin
          tf_q <= tf_new;
          x_q  <= tf_new - bsc_pkg::TfOffset;
        end
      end
      S_XX: if (mul_done) xx_q <= m;
      S_Y6: if (mul_done) y_q <= m;
      S_Y5: if (mul_done) y_q <= y_q + (m << 17) + (coef_i.p4 << 35);
      S_X3: if (mul_done) v_q <= 64'($signed(m) >>> 8);
      S_X2: if (mul_done) v_q <= v_q + (m << 12);
      S_X1: begin
        if (mul_done) begin
          xd_q  <= 64'($signed(m) >>> 33);
          hpa_q <= ap_q;
          pv_q  <= 1'b0;
        end
      end
      S_NUM: if (mul_done) v_q <= m;
      S_DIV: if (div_done) p_q <= dq;
      S_Q1:  if (mul_done) v_q <= m;
      S_Q2:  if (mul_done) qq_q <= 64'($signed(m) >>> 25);
      S_R: begin
        if (mul_done) begin
          v_q <= 64'($signed(p_q + qq_q + 64'($signed(m) >>> 19)) >>> 8)
                 + (coef_i.p7 << 4);
        end
      end
      S_HPA: begin
        hpa_q <= hpa_quot;
        pv_q  <= 1'b1;
      end
      S_OUT: begin
        if (!out_valid_o || out_ready_i) begin
          temperature_centi_o <= tc_sat;
          pressure_out_o      <= hpa_q;
          pressure_valid_o    <= pv_q;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[hw/rtl/barometric_sensor_compensation.sv]
// Top level of the barometric sensor compensation block.
//
// Channel   Direction  Handshake                 Payload
// config    in         cfg_we_i                  cfg_idx_i, cfg_data_i
// input     in         in_valid_i / in_ready_o   raw_temperature_i, raw_pressure_i
// result    out        out_valid_o / out_ready_i temperature_centi_o, pressure_out_o,
//                                                pressure_valid_o
//
// A compensated item is popped from the queue, then takes 13 products on the shared
// multiplier (start, three 32x32 partial products, finish), a signed divide and
// reciprocal scaling to hPa before the result is loaded.
// With a zero pressure divisor the item ends after the ninth product.
// A two-entry queue lets the input accept while the back is busy or stalled.
// Reset is asynchronous, active low, and clears configuration and control state.
`default_nettype none
module barometric_sensor_compensation (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [bsc_pkg::CfgW-1:0]  cfg_data_i,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic [bsc_pkg::RawW-1:0]  raw_temperature_i,
  input  wire logic [bsc_pkg::RawW-1:0]  raw_pressure_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [15:0]             temperature_centi_o,
  output logic [bsc_pkg::RawW-1:0]       pressure_out_o,
  output logic                           pressure_valid_o
);

  bsc_pkg::q_ctl_t qc;
  bsc_pkg::item_t  push_item, head_item;
  bsc_pkg::coef_t  coef;

  bsc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .q_full_i          (qc.full),
    .q_push_o          (qc.push),
    .q_item_o          (push_item),
    .coef_o            (coef)
  );

  bsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qc.push),
    .item_i  (push_item),
    .pop_i   (qc.pop),
    .item_o  (head_item),
    .full_o  (qc.full),
    .empty_o (qc.empty)
  );

  bsc_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .coef_i              (coef),
    .q_empty_i           (qc.empty),
    .q_item_i            (head_item),
    .q_pop_o             (qc.pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .temperature_centi_o (temperature_centi_o),
    .pressure_out_o      (pressure_out_o),
    .pressure_valid_o    (pressure_valid_o)
  );

endmodule
`default_nettype wire

[hw/rtl/bsc_checker.sv]
// Port-level checks for the barometric sensor compensation block, with its bind.
`default_nettype none
module bsc_port_checks (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      cfg_we_i,
  input wire logic [1:0]                cfg_idx_i,
  input wire logic [bsc_pkg::CfgW-1:0]  cfg_data_i,
  input wire logic                      in_valid_i,
  input wire logic                      in_ready_o,
  input wire logic [bsc_pkg::RawW-1:0]  raw_temperature_i,
  input wire logic [bsc_pkg::RawW-1:0]  raw_pressure_i,
  input wire logic                      out_valid_o,
  input wire logic                      out_ready_i,
  input wire logic signed [15:0]        temperature_centi_o,
  input wire logic [bsc_pkg::RawW-1:0]  pressure_out_o,
  input wire logic                      pressure_valid_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(temperature_centi_o)
      && $stable(pressure_out_o) && $stable(pressure_valid_o))
    else $error("result payload changed while stalled");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // the queue is empty right after reset, so input is accepted
  a_rst_ready: assert property (@(posedge clk_i) !rst_ni |=> in_ready_o)
    else $error("input not ready after reset");

endmodule

bind barometric_sensor_compensation bsc_port_checks u_bsc_port_checks (.*);
`default_nettype wire

[verif/bsc_checker.sv]
// Checker: watches the input and result channels, predicts compensated readings, compares.
`timescale 1ns / 1ps
module bsc_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [1:0]                cfg_idx_i,
  input  wire logic [bsc_pkg::CfgW-1:0]  cfg_data_i,
  input  wire logic                      in_valid_i,
  input  wire logic                      in_ready_i,
  input  wire logic [bsc_pkg::RawW-1:0]  raw_temperature_i,
  input  wire logic [bsc_pkg::RawW-1:0]  raw_pressure_i,
  input  wire logic                      out_valid_i,
  input  wire logic                      out_ready_i,
  input  wire logic signed [15:0]        temperature_centi_i,
  input  wire logic [bsc_pkg::RawW-1:0]  pressure_out_i,
  input  wire logic                      pressure_valid_i,
  output int                             fail_count_o,
  output int                             pending_o,
  output int                             readings_o,
  output int                             invalid_o
);

  typedef struct packed {
    logic [15:0] temp_centi;
    logic [19:0] press;
    logic        press_ok;
  } reading_t;

  logic [47:0] cal_temp, cal_pa, cal_pb, cal_pc;
  reading_t    expected_readings[$];

  function automatic logic signed [63:0] cal_word(input logic [47:0] r, input int k);
    logic [15:0] w;
    w = r[16*k +: 16];
    return {{48{w[15]}}, w};
  endfunction

  // Signed divide truncating toward zero, wrapping on overflow
  function automatic logic [63:0] div_trunc(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] mn, md, q;
    mn = n[63] ? -n : n;
    md = d[63] ? -d : d;
    q  = mn / md;
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic reading_t compensate(input logic [19:0] at, input logic [19:0] ap);
    logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] a, d, b, tfine, tc, x, y, p, q, r;
    logic [63:0] px;
    reading_t res;
    t1 = {48'd0, cal_temp[15:0]};
    t2 = cal_word(cal_temp, 1);  t3 = cal_word(cal_temp, 2);
    p1 = {48'd0, cal_pa[15:0]};
    p2 = cal_word(cal_pa, 1);    p3 = cal_word(cal_pa, 2);
    p4 = cal_word(cal_pb, 0);    p5 = cal_word(cal_pb, 1);  p6 = cal_word(cal_pb, 2);
    p7 = cal_word(cal_pc, 0);    p8 = cal_word(cal_pc, 1);  p9 = cal_word(cal_pc, 2);
    // fine temperature
    a = ((($signed({44'd0, at}) >>> 3) - (t1 <<< 1)) * t2) >>> 11;
    d = ($signed({44'd0, at}) >>> 4) - t1;
    b = (((d * d) >>> 12) * t3) >>> 14;
    tfine = a + b;
    tc = (tfine * 5 + 128) >>> 8;
    if (tc > 32767) tc = 32767;
    if (tc < -32768) tc = -32768;
    res.temp_centi = tc[15:0];
    // pressure, wrapping 64-bit
    x = tfine - 128000;
    y = x * x * p6;
    y = y + ((x * p5) <<< 17);
    y = y + (p4 <<< 35);
    x = ((x * x * p3) >>> 8) + ((x * p2) <<< 12);
    x = (((64'sd1 <<< 47) + x) * p1) >>> 33;
    if (x == 0) begin
      res.press = ap;
      res.press_ok = 1'b0;
      return res;
    end
    p = 64'sd1048576 - $signed({44'd0, ap});
    p = div_trunc(((p <<< 31) - y) * 3125, x);
    q = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
    r = (p8 * p) >>> 19;
    p = ((p + q + r) >>> 8) + (p7 <<< 4);
    px = {32'd0, p[31:0]} / 64'd25600;
    res.press = px[19:0];
    res.press_ok = 1'b1;
    return res;
  endfunction

  assign pending_o = expected_readings.size();

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      cal_temp <= '0; cal_pa <= '0; cal_pb <= '0; cal_pc <= '0;
      fail_count_o <= 0;
      readings_o <= 0;
      invalid_o <= 0;
      expected_readings.delete();
    end else begin
      // prediction on accepted input transaction (uses registers before this edge's write)
      if (in_valid_i && in_ready_i)
        expected_readings.push_back(compensate(raw_temperature_i, raw_pressure_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bsc_pkg::RegTemp:   cal_temp <= cfg_data_i;
          bsc_pkg::RegPressA: cal_pa   <= cfg_data_i;
          bsc_pkg::RegPressB: cal_pb   <= cfg_data_i;
          bsc_pkg::RegPressC: cal_pc   <= cfg_data_i;
          default: ;
        endcase
      end
      // compare result transaction
      if (out_valid_i && out_ready_i) begin
        readings_o <= readings_o + 1;
        if (expected_readings.size() == 0) begin
          $error("unexpected result transaction");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = expected_readings.pop_front();
          if (!want.press_ok) invalid_o <= invalid_o + 1;
          if (temperature_centi_i !== want.temp_centi ||
              pressure_out_i !== want.press || pressure_valid_i !== want.press_ok)
            fail_count_o <= fail_count_o + 1;
          if (temperature_centi_i !== want.temp_centi)
            $error("temperature_centi: expected %0d actual %0d",
                   $signed(want.temp_centi), temperature_centi_i);
          if (pressure_out_i !== want.press)
            $error("pressure_out: expected %0d actual %0d", want.press, pressure_out_i);
          if (pressure_valid_i !== want.press_ok)
            $error("pressure_valid: expected %0d actual %0d", want.press_ok,
                   pressure_valid_i);
        end
      end
    end
  end
endmodule

[verif/tb_barometric_sensor_compensation.sv]
// Testbench top: stimulus for the compensation block, idle phases and the verdict.
`timescale 1ns / 1ps
module tb_barometric_sensor_compensation;

  localparam int CycleLimit = 3_000_000;
  localparam int DrainCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = bsc_pkg::RegTemp;
  logic [bsc_pkg::CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic [bsc_pkg::RawW-1:0] raw_temperature_i = '0, raw_pressure_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, out_valid_o, pressure_valid_o;
  logic signed [15:0] temperature_centi_o;
  logic [bsc_pkg::RawW-1:0] pressure_out_o;
  int fail_count, pending, readings, invalid_count;
  int cycles = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;
  int sent = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  barometric_sensor_compensation dut (.*);

  bsc_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .raw_temperature_i, .raw_pressure_i,
    .out_valid_i(out_valid_o), .out_ready_i, .temperature_centi_i(temperature_centi_o),
    .pressure_out_i(pressure_out_o), .pressure_valid_i(pressure_valid_o),
    .fail_count_o(fail_count), .pending_o(pending), .readings_o(readings),
    .invalid_o(invalid_count)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk_i)
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);

  // valid stays high after acceptance so the next transaction can follow at once
  task automatic send_reading(input logic [19:0] t, input logic [19:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_temperature_i <= t;
    raw_pressure_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cal(input logic [1:0] idx, input logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // datasheet-like calibration, with random perturbation when jitter is set
  task automatic load_typical(input bit jitter);
    logic [15:0] j;
    j = jitter ? 16'($urandom_range(200)) : 16'd0;
    write_cal(bsc_pkg::RegTemp,   {16'd50 + j, 16'd26435, 16'd27504 + j});
    write_cal(bsc_pkg::RegPressA, {16'd3024, -16'sd10685 - j, 16'd36477 + j});
    write_cal(bsc_pkg::RegPressB, {-16'sd7 , 16'd140 + j, 16'd2855});
    write_cal(bsc_pkg::RegPressC, {16'd6000 - j, -16'sd14600, 16'd15500});
  endtask

  task automatic load_random();
    write_cal(bsc_pkg::RegTemp,   48'({$urandom, $urandom}));
    write_cal(bsc_pkg::RegPressA, 48'({$urandom, $urandom}));
    write_cal(bsc_pkg::RegPressB, 48'({$urandom, $urandom}));
    write_cal(bsc_pkg::RegPressC, 48'({$urandom, $urandom}));
  endtask

  initial begin
    logic [19:0] rt, rp;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all-zero calibration: divisor is zero, raw pressure passes through
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    wait_idle();

    // extreme calibration words
    write_cal(bsc_pkg::RegTemp, 48'hFFFF_FFFF_FFFF);
    write_cal(bsc_pkg::RegPressA, 48'h8000_8000_FFFF);
    write_cal(bsc_pkg::RegPressB, 48'h7FFF_7FFF_7FFF);
    write_cal(bsc_pkg::RegPressC, 48'h8000_8000_8000);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'h55555, 20'hAAAAA);
    wait_idle();
    write_cal(bsc_pkg::RegTemp, 48'h7FFF_7FFF_0000);
    write_cal(bsc_pkg::RegPressA, 48'h7FFF_7FFF_0001);
    send_reading(20'hFFFFF, 20'h80000);
    send_reading(20'd0, 20'h7FFFF);
    wait_idle();

    // typical calibration, typical readings and extremes
    load_typical(1'b0);
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hAAAAA, 20'h55555);
    send_reading(20'd400000, 20'd200000);
    send_reading(20'd700000, 20'd600000);
    wait_idle();

    // random phases with different idle patterns and calibrations
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      if (ph % 3 == 2) load_random(); else load_typical(1'b1);
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(9) < 7) begin
          rt = 20'($urandom_range(600000, 350000));
          rp = 20'($urandom_range(500000, 200000));
        end else begin
          rt = 20'($urandom);
          rp = 20'($urandom);
        end
        send_reading(rt, rp);
        if (k == 50) wait_results();
      end
      wait_idle();
    end

    $display("Sent %0d readings, checked %0d results (%0d with zero divisor).",
             sent, readings, invalid_count);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
